[sv/tcce_pkg.sv]
// Shared definitions for the text console cursor engine: operation and character codes,
// microprogram step codes, the control word layout and the microcode ROM.
// No dependencies; used by tcce_seq and text_console_cursor_engine.
package tcce_pkg;

    localparam int DEF_COLS      = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GOTO  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] CH_BACK  = 8'h80;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] ST_INIT     = 4'd0;
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd1;
    localparam logic [STEP_W-1:0] ST_PUT      = 4'd2;
    localparam logic [STEP_W-1:0] ST_SCR_PRE  = 4'd3;
    localparam logic [STEP_W-1:0] ST_SCR_COPY = 4'd4;
    localparam logic [STEP_W-1:0] ST_SCR_FILL = 4'd5;
    localparam logic [STEP_W-1:0] ST_GOTO     = 4'd6;
    localparam logic [STEP_W-1:0] ST_CLEAR    = 4'd7;
    localparam logic [STEP_W-1:0] ST_HOME     = 4'd8;
    localparam logic [STEP_W-1:0] ST_READ     = 4'd9;
    localparam logic [STEP_W-1:0] ST_RD_DONE  = 4'd10;

    localparam logic [1:0] WE_NONE   = 2'd0;
    localparam logic [1:0] WE_ALWAYS = 2'd1;
    localparam logic [1:0] WE_PRINT  = 2'd2;

    localparam logic WS_FILL  = 1'b0;
    localparam logic WS_RDATA = 1'b1;

    localparam logic WA_PTR    = 1'b0;
    localparam logic WA_CURSOR = 1'b1;

    localparam logic [1:0] RS_ROW      = 2'd0;
    localparam logic [1:0] RS_NEXT_ROW = 2'd1;
    localparam logic [1:0] RS_INDEX    = 2'd2;

    localparam logic [1:0] CUR_HOLD = 2'd0;
    localparam logic [1:0] CUR_PUT  = 2'd1;
    localparam logic [1:0] CUR_GOTO = 2'd2;
    localparam logic [1:0] CUR_HOME = 2'd3;

    localparam logic [1:0] JC_NEVER      = 2'd0;
    localparam logic [1:0] JC_SCROLL     = 2'd1;
    localparam logic [1:0] JC_MORE_COPY  = 2'd2;
    localparam logic [1:0] JC_MORE_CELLS = 2'd3;

    typedef struct packed {
        logic              idle;
        logic [1:0]        wen;
        logic              wsel;
        logic              wadr;
        logic              ren;
        logic [1:0]        rsel;
        logic              ptr_inc;
        logic              fill_space;
        logic [1:0]        cur;
        logic [1:0]        cond;
        logic [STEP_W-1:0] tgt;
        logic              done;
        logic              out_rd;
    } t_ctrl;

    typedef struct packed {
        logic       accept;
        logic [1:0] opcode;
        logic       stall;
        logic       scroll;
        logic       more_copy;
        logic       more_cells;
    } t_stat;

    function automatic logic is_printable(logic [7:0] ch);
        return (ch >= CH_SPACE) && (ch != CH_BACK);
    endfunction

    function automatic logic [STEP_W-1:0] entry_step(logic [1:0] op);
        logic [STEP_W-1:0] s;
        unique case (op)
            OP_PUT:   s = ST_PUT;
            OP_GOTO:  s = ST_GOTO;
            OP_CLEAR: s = ST_CLEAR;
            OP_READ:  s = ST_READ;
        endcase
        return s;
    endfunction

    function automatic t_ctrl ucode(logic [STEP_W-1:0] step);
        t_ctrl c;
        c     = '0;
        c.tgt = ST_IDLE;
        unique case (step)
            ST_INIT, ST_CLEAR: begin
                c.wen     = WE_ALWAYS;
                c.wsel    = WS_FILL;
                c.wadr    = WA_PTR;
                c.ptr_inc = 1'b1;
                c.cond    = JC_MORE_CELLS;
                c.tgt     = step;
            end
            ST_IDLE: begin
                c.idle = 1'b1;
            end
            ST_PUT: begin
                c.wen  = WE_PRINT;
                c.wsel = WS_FILL;
                c.wadr = WA_CURSOR;
                c.cur  = CUR_PUT;
                c.cond = JC_SCROLL;
                c.tgt  = ST_SCR_PRE;
                c.done = 1'b1;
            end
            ST_SCR_PRE: begin
                c.ren        = 1'b1;
                c.rsel       = RS_ROW;
                c.fill_space = 1'b1;
            end
            ST_SCR_COPY: begin
                c.wen     = WE_ALWAYS;
                c.wsel    = WS_RDATA;
                c.wadr    = WA_PTR;
                c.ren     = 1'b1;
                c.rsel    = RS_NEXT_ROW;
                c.ptr_inc = 1'b1;
                c.cond    = JC_MORE_COPY;
                c.tgt     = ST_SCR_COPY;
            end
            ST_SCR_FILL: begin
                c.wen     = WE_ALWAYS;
                c.wsel    = WS_FILL;
                c.wadr    = WA_PTR;
                c.ptr_inc = 1'b1;
                c.cond    = JC_MORE_CELLS;
                c.tgt     = ST_SCR_FILL;
                c.done    = 1'b1;
            end
            ST_GOTO: begin
                c.cur  = CUR_GOTO;
                c.done = 1'b1;
            end
            ST_HOME: begin
                c.cur  = CUR_HOME;
                c.done = 1'b1;
            end
            ST_READ: begin
                c.ren  = 1'b1;
                c.rsel = RS_INDEX;
            end
            ST_RD_DONE: begin
                c.out_rd = 1'b1;
                c.done   = 1'b1;
            end
            default: begin
                c.idle = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

[sv/text_console_cursor_engine.sv]
// Top level of the text console cursor engine: screen memory, cursor and datapath.
// Depends on tcce_pkg and instantiates tcce_seq.

// The engine keeps a ROWS x COLS screen of 16-bit cells and a cursor, driven by a small
// microprogram with one memory write and one memory read per cycle. After reset it zeroes
// the screen with s_tready low; attribute writes are taken meanwhile. Once accepted, an
// item runs its microprogram steps: put writes a printable character at the cursor and
// moves the cursor, goto moves the cursor, read fetches the cell and then returns it, and
// clear fills every cell and then homes the cursor. A put that scrolls then copies rows
// 1 to ROWS-1 up one row through the single memory port pair and fills the last row with
// spaces. A result waits in the output register; the next request is accepted while it
// waits, and the engine stalls only if a second result is ready before the first is taken.
module text_console_cursor_engine #(
    parameter int COLS      = tcce_pkg::DEF_COLS,
    parameter int ROWS      = tcce_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tcce_pkg::DEF_TAB_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // char_code[7:0], target_col[14:8], target_row[19:15],
                                    // cell_index[30:20], zero pad[31]
    input  logic [1:0]  i_s_tuser,  // opcode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // cursor_location[10:0], cell_data[26:11], zero pad[31:27]
    output logic        o_m_tuser   // scrolled[0]
);
    import tcce_pkg::*;

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CXW   = $clog2(COLS + TAB_WIDTH);
    localparam int RXW   = RW + 1;
    localparam int XW    = (AW + 1 > 11) ? AW + 1 : 11;
    localparam int LW    = (AW > 11) ? AW : 11;
    localparam int GCW   = (CW > 7) ? CW : 7;
    localparam int GRW   = (RW > 5) ? RW : 5;

    t_ctrl             w_ctrl;
    t_stat             w_stat;
    logic              w_done;
    logic [STEP_W-1:0] w_step;
    logic              w_accept;
    logic              w_stall;
    logic              w_load;

    logic [7:0]        r_attr;
    logic [7:0]        r_ch;
    logic [6:0]        r_tcol;
    logic [4:0]        r_trow;
    logic [10:0]       r_idx;
    logic [15:0]       r_fill;
    logic [AW-1:0]     r_ptr;
    logic              r_scrl;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_row;

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rdata;
    logic              r_rd_ok;

    logic              r_ovalid;
    logic [10:0]       r_oloc;
    logic [15:0]       r_odata;
    logic              r_oscr;

    logic [CXW-1:0]    w_tab [COLS];
    logic [CXW-1:0]    w_col_x;
    logic [RXW-1:0]    w_row_x;
    logic              w_put_ovf;
    logic [CW-1:0]     w_put_col;
    logic [RW-1:0]     w_put_row;
    logic [CW-1:0]     w_goto_col;
    logic [RW-1:0]     w_goto_row;
    logic [AW-1:0]     w_cur_pos;
    logic [LW-1:0]     w_loc;
    logic [XW-1:0]     w_raddr;
    logic              w_rd_in;
    logic              w_mem_we;
    logic [AW-1:0]     w_waddr;
    logic [15:0]       w_wdata;

    tcce_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_done  (w_done),
        .o_step  (w_step)
    );

    assign o_s_tready = w_ctrl.idle;
    assign w_accept   = i_s_tvalid & w_ctrl.idle;
    assign w_stall    = w_done & r_ovalid & ~i_m_tready;
    assign w_load     = w_done & ~w_stall;

    assign w_stat.accept     = w_accept;
    assign w_stat.opcode     = i_s_tuser;
    assign w_stat.stall      = w_stall;
    assign w_stat.scroll     = w_put_ovf;
    assign w_stat.more_copy  = (r_ptr != AW'(CELLS - COLS - 1));
    assign w_stat.more_cells = (r_ptr != AW'(CELLS - 1));

    for (genvar c = 0; c < COLS; c++) begin : g_tab
        assign w_tab[c] = CXW'((c / TAB_WIDTH + 1) * TAB_WIDTH);
    end

    always_comb begin
        w_col_x = CXW'(r_col);
        w_row_x = RXW'(r_row);
        case (r_ch)
            CH_BACK: begin
                if (r_col != '0) begin
                    w_col_x = CXW'(r_col) - 1'b1;
                end
            end
            CH_TAB: begin
                w_col_x = w_tab[r_col];
            end
            CH_CR: begin
                w_col_x = '0;
            end
            CH_LF: begin
                w_col_x = '0;
                w_row_x = RXW'(r_row) + 1'b1;
            end
            default: begin
                if (r_ch >= CH_SPACE) begin
                    w_col_x = CXW'(r_col) + 1'b1;
                end
            end
        endcase
        if (w_col_x >= CXW'(COLS)) begin
            w_col_x = '0;
            w_row_x = w_row_x + 1'b1;
        end
    end

    assign w_put_ovf = (w_row_x >= RXW'(ROWS));
    assign w_put_col = CW'(w_col_x);
    assign w_put_row = w_put_ovf ? RW'(ROWS - 1) : RW'(w_row_x);

    assign w_goto_col = (GCW'(r_tcol) > GCW'(COLS - 1)) ? CW'(COLS - 1) : CW'(r_tcol);
    assign w_goto_row = (GRW'(r_trow) > GRW'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(r_trow);

    always_comb begin
        unique case (w_ctrl.cur)
            CUR_HOLD: begin
                n_col = r_col;
                n_row = r_row;
            end
            CUR_PUT: begin
                n_col = w_put_col;
                n_row = w_put_row;
            end
            CUR_GOTO: begin
                n_col = w_goto_col;
                n_row = w_goto_row;
            end
            CUR_HOME: begin
                n_col = '0;
                n_row = '0;
            end
        endcase
    end

    assign w_cur_pos = AW'(AW'(r_row) * AW'(COLS) + AW'(r_col));
    assign w_loc     = LW'(LW'(n_row) * LW'(COLS) + LW'(n_col));

    always_comb begin
        unique case (w_ctrl.rsel)
            RS_ROW:      w_raddr = XW'(r_ptr) + XW'(COLS);
            RS_NEXT_ROW: w_raddr = XW'(r_ptr) + XW'(COLS + 1);
            RS_INDEX:    w_raddr = XW'(r_idx);
            default:     w_raddr = '0;
        endcase
    end

    assign w_rd_in  = (w_raddr < XW'(CELLS));
    assign w_mem_we = ~w_stall & ((w_ctrl.wen == WE_ALWAYS) |
                                  ((w_ctrl.wen == WE_PRINT) & is_printable(r_ch)));
    assign w_waddr  = (w_ctrl.wadr == WA_CURSOR) ? w_cur_pos : r_ptr;
    assign w_wdata  = (w_ctrl.wsel == WS_RDATA) ? r_rdata : r_fill;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.ren) begin
            r_rd_ok <= w_rd_in;
            if (w_rd_in) begin
                r_rdata <= r_mem[w_raddr[AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= i_s_tdata[7:0];
            r_tcol <= i_s_tdata[14:8];
            r_trow <= i_s_tdata[19:15];
            r_idx  <= i_s_tdata[30:20];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr   <= '0;
            r_fill   <= '0;
            r_ptr    <= '0;
            r_scrl   <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_attr <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_ptr  <= '0;
                r_scrl <= 1'b0;
                if (i_s_tuser == OP_PUT) begin
                    r_fill <= {r_attr, i_s_tdata[7:0]};
                end else if (i_s_tuser == OP_CLEAR) begin
                    r_fill <= {i_s_tdata[7:0], CH_SPACE};
                end
            end else if (!w_stall) begin
                if (w_ctrl.ptr_inc) begin
                    r_ptr <= r_ptr + 1'b1;
                end
                if (w_ctrl.fill_space) begin
                    r_fill <= {8'h00, CH_SPACE};
                end
                if (w_ctrl.cur == CUR_PUT) begin
                    r_scrl <= w_put_ovf;
                end
                r_col <= n_col;
                r_row <= n_row;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oloc  <= w_loc[10:0];
            r_odata <= (w_ctrl.out_rd & r_rd_ok) ? r_rdata : 16'h0000;
            r_oscr  <= r_scrl;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'b00000, r_odata, r_oloc};
    assign o_m_tuser  = r_oscr;

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_s_tready)
        else $error("Sequencer did not return to idle after a result.");

    a_scroll_only_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_scrl) |-> (w_step == ST_SCR_FILL))
        else $error("Scroll flag reported outside the scroll fill step.");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CXW'(r_col) < CXW'(COLS)) && (RXW'(r_row) < RXW'(ROWS)))
        else $error("Cursor left the screen.");

endmodule

[sv/tcce_seq.sv]
// Microprogram sequencer: step counter, microcode ROM lookup and jump logic.
// Depends on tcce_pkg for the control word, status struct and ROM.
module tcce_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcce_pkg::t_stat             i_stat,
    output tcce_pkg::t_ctrl             o_ctrl,
    output logic                        o_done,
    output logic [tcce_pkg::STEP_W-1:0] o_step
);
    import tcce_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_ctrl;
    logic              w_cond;

    assign w_ctrl = ucode(r_step);
    assign o_ctrl = w_ctrl;
    assign o_step = r_step;

    always_comb begin
        unique case (w_ctrl.cond)
            JC_NEVER:      w_cond = 1'b0;
            JC_SCROLL:     w_cond = i_stat.scroll;
            JC_MORE_COPY:  w_cond = i_stat.more_copy;
            JC_MORE_CELLS: w_cond = i_stat.more_cells;
        endcase
    end

    assign o_done = w_ctrl.done & ~w_cond;

    always_comb begin
        n_step = r_step;
        if (i_stat.stall) begin
            n_step = r_step;
        end else if (w_ctrl.idle) begin
            if (i_stat.accept) begin
                n_step = entry_step(i_stat.opcode);
            end
        end else if (w_cond) begin
            n_step = w_ctrl.tgt;
        end else if (w_ctrl.done) begin
            n_step = ST_IDLE;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_INIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[tb/text_console_cursor_engine_test.sv]
// Self-checking testbench for text_console_cursor_engine: a local screen model predicts
// every result of put, goto, clear and read requests under random stalls on both streams.
// Depends on tcce_pkg and the engine RTL.
`timescale 1ns / 1ps

module text_console_cursor_engine_test;
    import tcce_pkg::*;

    localparam int    COLS         = DEF_COLS;
    localparam int    ROWS         = DEF_ROWS;
    localparam int    TAB_WIDTH    = DEF_TAB_WIDTH;
    localparam int    CELLS        = COLS * ROWS;
    localparam int    RANDOM_ITEMS = 1700;
    localparam int    RANDOM_PHASE = 212;
    localparam int    DRAIN_CYCLES = 20;
    localparam longint CYCLE_LIMIT = 64'd4 * (CELLS + (RANDOM_ITEMS + 100) * (CELLS + 2 + 22));

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] idx;
    } t_console_request;

    typedef struct packed {
        logic [10:0] location;
        logic [15:0] cell_data;
        logic        scrolled;
    } t_console_outcome;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wen   = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata   = 32'h0;
    logic [1:0]  i_s_tuser   = OP_PUT;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b1;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;

    logic [15:0]      screen_image [CELLS];
    int               cursor_col;
    int               cursor_row;
    logic [7:0]       text_attr;
    t_console_outcome pending_outcomes [$];

    bit     no_idle;
    int     sink_hold;
    int     mismatch_count;
    int     requests_sent;
    int     results_checked;
    int     scroll_count;
    int     clear_count;
    int     read_count;
    longint cycle_count;

    text_console_cursor_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_outcomes.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_console_outcome apply_console_request(t_console_request r);
        t_console_outcome res;
        int n;
        res = '0;
        case (r.op)
            OP_PUT: begin
                if (r.ch == CH_BACK) begin
                    if (cursor_col > 0) cursor_col--;
                end else if (r.ch == CH_TAB) begin
                    cursor_col = cursor_col + TAB_WIDTH - (cursor_col % TAB_WIDTH);
                end else if (r.ch == CH_CR) begin
                    cursor_col = 0;
                end else if (r.ch == CH_LF) begin
                    cursor_col = 0;
                    cursor_row++;
                end else if (r.ch >= CH_SPACE) begin
                    screen_image[cursor_row * COLS + cursor_col] = {text_attr, r.ch};
                    cursor_col++;
                end
                if (cursor_col >= COLS) begin
                    cursor_col = 0;
                    cursor_row++;
                end
                if (cursor_row >= ROWS) begin
                    for (n = 0; n < CELLS - COLS; n++) screen_image[n] = screen_image[n + COLS];
                    for (n = CELLS - COLS; n < CELLS; n++) screen_image[n] = {8'h00, CH_SPACE};
                    cursor_row   = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            OP_GOTO: begin
                cursor_col = (r.col > COLS - 1) ? COLS - 1 : int'(r.col);
                cursor_row = (r.row > ROWS - 1) ? ROWS - 1 : int'(r.row);
            end
            OP_CLEAR: begin
                for (n = 0; n < CELLS; n++) screen_image[n] = {r.ch, CH_SPACE};
                cursor_col = 0;
                cursor_row = 0;
            end
            default: begin
                if (r.idx < CELLS) res.cell_data = screen_image[r.idx];
            end
        endcase
        res.location = 11'(cursor_row * COLS + cursor_col);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("Mismatch at result %0d: %s", results_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_result();
        t_console_outcome want;
        if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected result, tdata %08h", o_m_tdata));
        end else begin
            want = pending_outcomes.pop_front();
            if (o_m_tdata[10:0] !== want.location)
                report_mismatch($sformatf("cursor_location %0d, expected %0d",
                                          o_m_tdata[10:0], want.location));
            if (o_m_tdata[26:11] !== want.cell_data)
                report_mismatch($sformatf("cell_data %04h, expected %04h",
                                          o_m_tdata[26:11], want.cell_data));
            if (o_m_tuser !== want.scrolled)
                report_mismatch($sformatf("scrolled %0b, expected %0b",
                                          o_m_tuser, want.scrolled));
        end
        results_checked++;
    endtask

    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            check_result();
            sink_hold = no_idle ? 0 : $urandom_range(0, 10);
            i_m_tready <= (sink_hold == 0);
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_m_tready <= (sink_hold == 0);
        end
    end

    task automatic send_request(t_console_request r);
        int gap;
        t_console_outcome res;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, r.idx, r.row, r.col, r.ch};
        i_s_tuser  <= r.op;
        do @(posedge i_clk); while (!o_s_tready);
        res = apply_console_request(r);
        pending_outcomes.push_back(res);
        requests_sent++;
        if (res.scrolled) scroll_count++;
        if (r.op == OP_CLEAR) clear_count++;
        if (r.op == OP_READ) read_count++;
    endtask

    function automatic t_console_request filler_request(logic [1:0] op);
        t_console_request r;
        r.op  = op;
        r.ch  = 8'($urandom);
        r.col = 7'($urandom);
        r.row = 5'($urandom);
        r.idx = 11'($urandom);
        return r;
    endfunction

    task automatic put_char(logic [7:0] ch);
        t_console_request r;
        r    = filler_request(OP_PUT);
        r.ch = ch;
        send_request(r);
    endtask

    task automatic goto_cell(logic [6:0] col, logic [4:0] row);
        t_console_request r;
        r     = filler_request(OP_GOTO);
        r.col = col;
        r.row = row;
        send_request(r);
    endtask

    task automatic read_cell(logic [10:0] idx);
        t_console_request r;
        r     = filler_request(OP_READ);
        r.idx = idx;
        send_request(r);
    endtask

    task automatic clear_screen(logic [7:0] attr);
        t_console_request r;
        r    = filler_request(OP_CLEAR);
        r.ch = attr;
        send_request(r);
    endtask

    task automatic set_text_attribute(logic [7:0] value);
        i_s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        text_attr = value;
    endtask

    function automatic t_console_request random_request();
        t_console_request r;
        int pick;
        int base;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            r    = filler_request(OP_PUT);
            pick = $urandom_range(0, 99);
            if (pick < 3) r.ch = CH_BACK;
            else if (pick < 6) r.ch = CH_TAB;
            else if (pick < 8) r.ch = CH_CR;
            else if (pick < 11) r.ch = CH_LF;
            else if (pick < 15) r.ch = 8'($urandom_range(0, 31));
        end else if (pick < 76) begin
            r = filler_request(OP_GOTO);
            if ($urandom_range(0, 4) != 0) begin
                r.col = 7'($urandom_range(0, COLS - 1));
                r.row = 5'($urandom_range(0, ROWS - 1));
            end
        end else if (pick < 98) begin
            r = filler_request(OP_READ);
            if ($urandom_range(0, 1) != 0) begin
                base = cursor_row * COLS + cursor_col - int'($urandom_range(0, 200));
                r.idx = 11'((base < 0) ? 0 : base);
            end
        end else begin
            r = filler_request(OP_CLEAR);
        end
        return r;
    endfunction

    task automatic apply_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < CELLS; n++) screen_image[n] = 16'h0000;
        cursor_col = 0;
        cursor_row = 0;
        text_attr  = 8'h00;
    endtask

    task automatic test_put_codes();
        put_char(8'h41);
        put_char(8'hFF);
        put_char(CH_SPACE);
        put_char(CH_BACK);
        put_char(CH_TAB);
        put_char(CH_CR);
        put_char(CH_BACK);
        put_char(CH_LF);
        put_char(8'h00);
        put_char(8'h1F);
        read_cell(11'd0);
        read_cell(11'd1);
    endtask

    task automatic test_goto_limits();
        goto_cell(7'd79, 5'd24);
        goto_cell(7'd127, 5'd31);
        goto_cell(7'd0, 5'd0);
    endtask

    task automatic test_wrap_and_scroll();
        goto_cell(7'd79, 5'd24);
        put_char(8'h5A);
        read_cell(11'(CELLS - COLS - 1));
        read_cell(11'(CELLS - 1));
        goto_cell(7'd78, 5'd24);
        put_char(CH_TAB);
        goto_cell(7'd5, 5'd24);
        put_char(CH_LF);
        read_cell(11'd2047);
    endtask

    task automatic test_clear_and_read();
        clear_screen(8'hFF);
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
        clear_screen(8'h00);
        read_cell(11'(CELLS));
    endtask

    task automatic test_random_traffic();
        int k;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % RANDOM_PHASE == 0) begin
                case (k / RANDOM_PHASE)
                    0:       set_text_attribute(8'h00);
                    1:       set_text_attribute(8'hFF);
                    default: set_text_attribute(8'($urandom));
                endcase
            end
            no_idle = (k % RANDOM_PHASE) >= 150 && (k % RANDOM_PHASE) < 190;
            send_request(random_request());
        end
        no_idle = 1'b0;
        i_s_tvalid <= 1'b0;
    endtask

    initial begin
        apply_reset();
        test_put_codes();
        set_text_attribute(8'hA5);
        test_goto_limits();
        test_wrap_and_scroll();
        set_text_attribute(8'hFF);
        test_clear_and_read();
        test_random_traffic();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results of %0d requests: %0d scrolls, %0d clears, %0d reads.",
                 results_checked, requests_sent, scroll_count, clear_count, read_count);
        $display("Run took %0d cycles and found %0d mismatches.", cycle_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
